// File: rtl/mpe_pkg.sv
// Shared widths, codes and handshake types for the midpoint ellipse outline unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package mpe_pkg;

   // Coordinate width of the centre; everything else is derived from it
   localparam int COORD_BITS = 12;
   localparam int RAD_BITS   = COORD_BITS - 1;
   localparam int SQ_BITS    = 2 * RAD_BITS;
   localparam int OUT_BITS   = COORD_BITS + 2;
   localparam int MUL_BITS   = 2 * COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * MUL_BITS;
   localparam int DEC_BITS   = 4 * COORD_BITS + 4;

   // Request payload layout, lowest field first
   localparam int CX_LSB         = 0;
   localparam int CY_LSB         = COORD_BITS;
   localparam int RX_LSB         = 2 * COORD_BITS;
   localparam int RY_LSB         = 2 * COORD_BITS + RAD_BITS;
   localparam int REQ_FIELD_BITS = 2 * COORD_BITS + 2 * RAD_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;

   // Response payload layout, lowest field first
   localparam int RSP_FIELD_BITS = 4 * OUT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Request kinds carried on req_tuser
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RX_SQ,
      ST_RY_SQ,
      ST_A2_RY,
      ST_D_INIT,
      ST_R1_P1,
      ST_R1_P2,
      ST_R1_TEST,
      ST_R1_ADD,
      ST_R1_FIN,
      ST_R2_SQX,
      ST_R2_MULB,
      ST_R2_SQY,
      ST_R2_DIFF,
      ST_R2_MULA,
      ST_R2_DINIT,
      ST_R2_MX,
      ST_R2_XSTEP,
      ST_R2_YSTEP,
      ST_EMIT
   } state_type;

   // Operand pairs for the shared multiplier
   typedef enum logic [3:0] {
      MUL_RX_RX,
      MUL_Y_Y,
      MUL_A2_Y,
      MUL_A2_2YM1,
      MUL_B2_2XP2,
      MUL_B2_2XP3,
      MUL_A2_2M2Y,
      MUL_SQ_2XP1,
      MUL_B2_PROD,
      MUL_YM1_SQ,
      MUL_A2_T,
      MUL_A2_3M2Y
   } mul_sel_type;

   // Register updates in the datapath
   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_A2_LOAD,
      DP_B2_INIT,
      DP_D_SUB4,
      DP_T_LOAD,
      DP_D_ADD4_FLAG,
      DP_R1_FINISH,
      DP_D_LOAD,
      DP_T_SUBB2,
      DP_D_ADD4,
      DP_R2_XSTEP,
      DP_R2_YSTEP,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      dp_op_type   dp_op;
   } mpe_cmd_type;

   typedef struct packed {
      logic cmp_gt;    // region one test: a^2*(2y-1) > b^2*(2x+2)
      logic y_zero;    // current y offset is zero
      logic rsp_free;  // output register can take a point this cycle
   } mpe_status_type;

endpackage

// File: rtl/mpe_ctrl.sv
// Sequencer for the midpoint ellipse outline unit: walks the multiply and
// update steps of one request. Depends on mpe_pkg.
module mpe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_op,
   input  mpe_pkg::mpe_status_type status,
   output mpe_pkg::mpe_cmd_type    cmd
);
   import mpe_pkg::*;

   state_type state_ff, state_in;
   logic      active_ff, active_in;
   logic      region_ff, region_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Hold state and outline flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= 1'b0;
         region_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         region_ff <= region_in;
      end
   end

   // Choose next state and issue commands
   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      region_in   = region_ff;
      cmd.mul_sel = MUL_RX_RX;
      cmd.dp_op   = DP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_START) begin
                  cmd.dp_op = DP_LOAD;
                  active_in = 1'b1;
                  region_in = 1'b0;
                  state_in  = ST_RX_SQ;
               end else if (active_ff) begin
                  state_in = region_ff ? ST_R2_MX : ST_R1_P1;
               end
            end
         end
         ST_RX_SQ: begin
            cmd.mul_sel = MUL_RX_RX;
            state_in    = ST_RY_SQ;
         end
         ST_RY_SQ: begin
            cmd.mul_sel = MUL_Y_Y;
            cmd.dp_op   = DP_A2_LOAD;
            state_in    = ST_A2_RY;
         end
         ST_A2_RY: begin
            cmd.mul_sel = MUL_A2_Y;
            cmd.dp_op   = DP_B2_INIT;
            state_in    = ST_D_INIT;
         end
         ST_D_INIT: begin
            cmd.dp_op = DP_D_SUB4;
            state_in  = ST_EMIT;
         end
         ST_R1_P1: begin
            cmd.mul_sel = MUL_A2_2YM1;
            state_in    = ST_R1_P2;
         end
         ST_R1_P2: begin
            cmd.mul_sel = MUL_B2_2XP2;
            cmd.dp_op   = DP_T_LOAD;
            state_in    = ST_R1_TEST;
         end
         ST_R1_TEST: begin
            // Stay in region one or set up region two
            if (status.cmp_gt) begin
               cmd.mul_sel = MUL_B2_2XP3;
               state_in    = ST_R1_ADD;
            end else begin
               region_in = 1'b1;
               state_in  = ST_R2_SQX;
            end
         end
         ST_R1_ADD: begin
            cmd.mul_sel = MUL_A2_2M2Y;
            cmd.dp_op   = DP_D_ADD4_FLAG;
            state_in    = ST_R1_FIN;
         end
         ST_R1_FIN: begin
            cmd.dp_op = DP_R1_FINISH;
            state_in  = ST_EMIT;
         end
         ST_R2_SQX: begin
            cmd.mul_sel = MUL_SQ_2XP1;
            state_in    = ST_R2_MULB;
         end
         ST_R2_MULB: begin
            cmd.mul_sel = MUL_B2_PROD;
            state_in    = ST_R2_SQY;
         end
         ST_R2_SQY: begin
            cmd.mul_sel = MUL_YM1_SQ;
            cmd.dp_op   = DP_D_LOAD;
            state_in    = ST_R2_DIFF;
         end
         ST_R2_DIFF: begin
            cmd.dp_op = DP_T_SUBB2;
            state_in  = ST_R2_MULA;
         end
         ST_R2_MULA: begin
            cmd.mul_sel = MUL_A2_T;
            state_in    = ST_R2_DINIT;
         end
         ST_R2_DINIT: begin
            cmd.dp_op = DP_D_ADD4;
            state_in  = ST_R2_MX;
         end
         ST_R2_MX: begin
            cmd.mul_sel = MUL_B2_2XP2;
            state_in    = ST_R2_XSTEP;
         end
         ST_R2_XSTEP: begin
            cmd.mul_sel = MUL_A2_3M2Y;
            cmd.dp_op   = DP_R2_XSTEP;
            state_in    = ST_R2_YSTEP;
         end
         ST_R2_YSTEP: begin
            cmd.dp_op = DP_R2_YSTEP;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // Hand the point to the output register; the final point ends the outline
            if (status.rsp_free) begin
               cmd.dp_op = DP_EMIT;
               if (status.y_zero) begin
                  active_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/mpe_datapath.sv
// Datapath of the midpoint ellipse outline unit: offsets, squared radii,
// decision value, one shared multiplier and the output register. Depends on mpe_pkg.
module mpe_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mpe_pkg::mpe_cmd_type                  cmd,
   output mpe_pkg::mpe_status_type               status,
   input  logic [mpe_pkg::COORD_BITS-1:0]        req_center_x,
   input  logic [mpe_pkg::COORD_BITS-1:0]        req_center_y,
   input  logic [mpe_pkg::RAD_BITS-1:0]          req_radius_x,
   input  logic [mpe_pkg::RAD_BITS-1:0]          req_radius_y,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mpe_pkg::RSP_FIELD_BITS-1:0]    rsp_fields,
   output logic                                  rsp_is_last
);
   import mpe_pkg::*;

   logic [COORD_BITS-1:0]      cx_ff, cx_in, cy_ff, cy_in;
   logic [RAD_BITS-1:0]        rx_ff, rx_in;
   logic [RAD_BITS-1:0]        x_ff, x_in, y_ff, y_in;
   logic [SQ_BITS-1:0]         a2_ff, a2_in, b2_ff, b2_in;
   logic signed [DEC_BITS-1:0] d_ff, d_in, t_ff, t_in, prod_ff;
   logic                       flag_ff, flag_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]        right_ff, right_in, left_ff, left_in;
   logic [OUT_BITS-1:0]        lower_ff, lower_in, upper_ff, upper_in;
   logic                       last_ff, last_in;

   logic [MUL_BITS-1:0]         xm, ym, am, bm, op_a, op_b;
   logic signed [MUL_BITS-1:0]  op_a_s, op_b_s;
   logic signed [PROD_BITS-1:0] prod_full;
   logic signed [DEC_BITS-1:0]  prod_x4, a2_ext, b2_ext;
   logic [OUT_BITS-1:0]         cx_ext, cy_ext, x_ext, y_ext;

   assign xm = MUL_BITS'(x_ff);
   assign ym = MUL_BITS'(y_ff);
   assign am = MUL_BITS'(a2_ff);
   assign bm = MUL_BITS'(b2_ff);

   // Select multiplier operands (modular arithmetic, read as two's complement)
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_RX_RX: begin
            op_a = MUL_BITS'(rx_ff);
            op_b = MUL_BITS'(rx_ff);
         end
         MUL_Y_Y: begin
            op_a = ym;
            op_b = ym;
         end
         MUL_A2_Y: begin
            op_a = am;
            op_b = ym;
         end
         MUL_A2_2YM1: begin
            op_a = am;
            op_b = (ym << 1) - MUL_BITS'(1);
         end
         MUL_B2_2XP2: begin
            op_a = bm;
            op_b = (xm << 1) + MUL_BITS'(2);
         end
         MUL_B2_2XP3: begin
            op_a = bm;
            op_b = (xm << 1) + MUL_BITS'(3);
         end
         MUL_A2_2M2Y: begin
            op_a = am;
            op_b = MUL_BITS'(2) - (ym << 1);
         end
         MUL_SQ_2XP1: begin
            op_a = (xm << 1) + MUL_BITS'(1);
            op_b = (xm << 1) + MUL_BITS'(1);
         end
         MUL_B2_PROD: begin
            op_a = bm;
            op_b = prod_ff[MUL_BITS-1:0];
         end
         MUL_YM1_SQ: begin
            op_a = ym - MUL_BITS'(1);
            op_b = ym - MUL_BITS'(1);
         end
         MUL_A2_T: begin
            op_a = am;
            op_b = t_ff[MUL_BITS-1:0];
         end
         MUL_A2_3M2Y: begin
            op_a = am;
            op_b = MUL_BITS'(3) - (ym << 1);
         end
         default: begin
            op_a = am;
            op_b = bm;
         end
      endcase
   end

   assign op_a_s    = op_a;
   assign op_b_s    = op_b;
   assign prod_full = op_a_s * op_b_s;

   // Register every product before use
   always_ff @(posedge clock) begin
      prod_ff <= DEC_BITS'(prod_full);
   end

   assign prod_x4 = {prod_ff[DEC_BITS-3:0], 2'b00};
   assign a2_ext  = DEC_BITS'(a2_ff);
   assign b2_ext  = DEC_BITS'(b2_ff);

   assign cx_ext = OUT_BITS'(cx_ff);
   assign cy_ext = OUT_BITS'(cy_ff);
   assign x_ext  = OUT_BITS'(x_ff);
   assign y_ext  = OUT_BITS'(y_ff);

   // Apply the commanded register update
   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      rx_in    = rx_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      a2_in    = a2_ff;
      b2_in    = b2_ff;
      d_in     = d_ff;
      t_in     = t_ff;
      flag_in  = flag_ff;
      right_in = right_ff;
      left_in  = left_ff;
      lower_in = lower_ff;
      upper_in = upper_ff;
      last_in  = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (cmd.dp_op)
         DP_NONE: begin
         end
         DP_LOAD: begin
            cx_in = req_center_x;
            cy_in = req_center_y;
            rx_in = req_radius_x;
            x_in  = '0;
            y_in  = req_radius_y;
         end
         DP_A2_LOAD: begin
            a2_in = prod_ff[SQ_BITS-1:0];
         end
         DP_B2_INIT: begin
            b2_in = prod_ff[SQ_BITS-1:0];
            d_in  = prod_x4 + a2_ext;
         end
         DP_D_SUB4: begin
            d_in = d_ff - prod_x4;
         end
         DP_T_LOAD: begin
            t_in = prod_ff;
         end
         DP_D_ADD4_FLAG: begin
            flag_in = !d_ff[DEC_BITS-1];
            d_in    = d_ff + prod_x4;
         end
         DP_R1_FINISH: begin
            if (flag_ff) begin
               d_in = d_ff + prod_x4;
               y_in = y_ff - RAD_BITS'(1);
            end
            x_in = x_ff + RAD_BITS'(1);
         end
         DP_D_LOAD: begin
            d_in = prod_ff;
         end
         DP_T_SUBB2: begin
            t_in = prod_ff - b2_ext;
         end
         DP_D_ADD4: begin
            d_in = d_ff + prod_x4;
         end
         DP_R2_XSTEP: begin
            if (d_ff[DEC_BITS-1]) begin
               d_in = d_ff + prod_x4;
               x_in = x_ff + RAD_BITS'(1);
            end
         end
         DP_R2_YSTEP: begin
            d_in = d_ff + prod_x4;
            y_in = y_ff - RAD_BITS'(1);
         end
         DP_EMIT: begin
            right_in     = cx_ext + x_ext;
            left_in      = cx_ext - x_ext;
            lower_in     = cy_ext + y_ext;
            upper_in     = cy_ext - y_ext;
            last_in      = (y_ff == '0);
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Hold the output valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      rx_ff    <= rx_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      a2_ff    <= a2_in;
      b2_ff    <= b2_in;
      d_ff     <= d_in;
      t_ff     <= t_in;
      flag_ff  <= flag_in;
      right_ff <= right_in;
      left_ff  <= left_in;
      lower_ff <= lower_in;
      upper_ff <= upper_in;
      last_ff  <= last_in;
   end

   assign status.cmp_gt   = (t_ff > prod_ff);
   assign status.y_zero   = (y_ff == '0);
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_fields  = {upper_ff, lower_ff, left_ff, right_ff};
   assign rsp_is_last = last_ff;

endmodule

// File: rtl/midpoint_ellipse_outline_unit.sv
// Top level of the midpoint ellipse outline unit: stream ports, payload
// packing, controller and datapath. Depends on mpe_pkg, mpe_ctrl and mpe_datapath.
//
// Usage:
//   The request channel (req_) carries a kind flag on req_tuser: start a new
//   ellipse from the centre and radii in req_tdata, or step to the next outline
//   point. A start returns the top point; each step returns the four mirrored
//   coordinates of the next point. rsp_tlast marks the final point (y offset 0),
//   after which steps return nothing until the next start. A step while idle
//   is taken and dropped.
//   Every request is stepped by the controller through one shared 25x25
//   multiplier whose product is registered before each use. A new request is
//   taken once the previous point sits in the output register, so a waiting
//   result does not block the next request.
//   When the receiver stalls, the point holds in the output register, and the
//   controller waits in its emit step with req_tready low when the next point
//   is ready. Reset (synchronous, active high) returns to idle with no outline
//   running and an empty output register.
module midpoint_ellipse_outline_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // center_x, center_y, radius_x, radius_y, zero fill
   input  logic [mpe_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // operation
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // right_x, left_x, lower_y, upper_y
   output logic [mpe_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // is_last
   output logic                                 rsp_tlast
);
   import mpe_pkg::*;

   mpe_cmd_type               cmd;
   mpe_status_type            status;
   logic [RSP_FIELD_BITS-1:0] rsp_fields;

   mpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   mpe_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_center_x (req_tdata[CX_LSB +: COORD_BITS]),
      .req_center_y (req_tdata[CY_LSB +: COORD_BITS]),
      .req_radius_x (req_tdata[RX_LSB +: RAD_BITS]),
      .req_radius_y (req_tdata[RY_LSB +: RAD_BITS]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_fields   (rsp_fields),
      .rsp_is_last  (rsp_tlast)
   );

   // Pad the packed point to whole bytes
   assign rsp_tdata = RSP_DATA_BITS'(rsp_fields);

endmodule
